>>> hdl/assert_macros.svh
// Assertion macros used by the top level of the packet segmenter.
// Depends on nothing; the includer must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> hdl/psc_pkg.sv
// Shared types, constants and CRC-8 functions for the packet segmenter.
// Depends on nothing; used by psc_framer, psc_emitter and the top level.
`default_nettype none

package psc_pkg;

  localparam int MAX_PAYLOAD = 63;
  localparam int SEQ_MODULUS = 16;

  localparam int BYTE_W = 8;
  localparam int SEQ_W  = 4;
  localparam int LEN_W  = 6;
  localparam int CRC_W  = 8;
  localparam int TYPE_W = 4;
  localparam int KIND_W = 2;
  localparam int OUT_DATA_W = 32;

  localparam logic [CRC_W-1:0]  CRC_POLY      = 8'h9B;
  localparam logic [TYPE_W-1:0] END_TYPE_CODE = 4'd15;

  localparam logic [KIND_W-1:0] KIND_ECHO    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TRAILER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

  localparam logic REG_PACKET_TYPE    = 1'b0;
  localparam logic REG_START_SEQUENCE = 1'b1;

  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_PAYLOAD);
  localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_MODULUS - 1);

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  end_seq;
    logic [LEN_W-1:0]  len;
    logic [CRC_W-1:0]  crc;
    logic [TYPE_W-1:0] ptype;
    logic              close;
    logic              last;
  } job_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] crc8_step(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ rev8(b);
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    return (s >= SEQ_LAST) ? '0 : s + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> hdl/packet_segmenter_crc8_core.sv
// Top level of the packet segmenter with CRC-8/WCDMA trailers.
// Depends on psc_pkg, psc_framer, psc_emitter and assert_macros.svh.
//
//   channel  direction  tdata                           tuser  tlast
//   in       slave      data_byte[7:0]                  -      last_byte
//   out      master     byte/seq/len/crc/type (30 bits) kind   run_end
//   cfg      write      index 0 packet_type, index 1 start_sequence
//
// A byte that neither fills nor ends a packet yields one echo word, so such bytes stream
// at one per cycle while the output is ready. A closing byte yields an echo and a trailer
// word and a last byte also an end word, all through the single output register they share.
// Reset is synchronous and clears all packet and handshake state; no clearing pass.
// A stall on the output holds the current word and, after one job, stalls the input.
`default_nettype none
`include "assert_macros.svh"

module packet_segmenter_crc8_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_index,
  input  wire logic [psc_pkg::SEQ_W-1:0]      cfg_wdata,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [psc_pkg::BYTE_W-1:0]     in_tdata,   // data_byte[7:0]
  input  wire logic                           in_tlast,
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // byte_out[7:0], sequence_number[11:8], payload_length[17:12],
  // crc_value[25:18], type_code[29:26], zeros[31:30]
  output      logic [psc_pkg::OUT_DATA_W-1:0] out_tdata,
  output      logic [psc_pkg::KIND_W-1:0]     out_tuser,  // kind[1:0]
  output      logic                           out_tlast
);

  psc_pkg::job_t job;
  logic          job_taken;

  psc_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .in_last   (in_tlast),
    .job       (job),
    .job_taken (job_taken)
  );

  psc_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_taken (job_taken),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

  `ASSERT_IMPL(a_end_is_run_end, out_tvalid && out_tuser == psc_pkg::KIND_END, out_tlast, "end word without run end")
  `ASSERT_IMPL(a_trailer_len, out_tvalid && out_tuser == psc_pkg::KIND_TRAILER, out_tdata[17:12] != 6'd0, "empty trailer")
  `ASSERT_IMPL(a_echo_clean, out_tvalid && out_tuser == psc_pkg::KIND_ECHO, out_tdata[25:12] == 14'd0, "echo carries length or crc")
  `ASSERT_NEXT(a_out_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "word changed under stall")

endmodule

`default_nettype wire

>>> hdl/psc_framer.sv
// Configuration registers, packet state and CRC step; a single job register.
// Depends on psc_pkg.
`default_nettype none

module psc_framer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic                       cfg_index,
  input  wire logic [psc_pkg::SEQ_W-1:0]  cfg_wdata,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [psc_pkg::BYTE_W-1:0] in_data,
  input  wire logic                       in_last,
  output      psc_pkg::job_t              job,
  input  wire logic                       job_taken
);

  logic [psc_pkg::TYPE_W-1:0] packet_type_r;
  logic [psc_pkg::SEQ_W-1:0]  start_seq_r;
  logic [psc_pkg::CRC_W-1:0]  crc_r, crc_nxt;
  logic [psc_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [psc_pkg::SEQ_W-1:0]  seq_r, seq_nxt;
  logic                       open_r;
  psc_pkg::job_t              job_r, job_nxt;

  logic                       accept;
  logic [psc_pkg::CRC_W-1:0]  base_crc, new_crc;
  logic [psc_pkg::LEN_W-1:0]  base_cnt, new_cnt;
  logic [psc_pkg::SEQ_W-1:0]  base_seq, next_seq;
  logic                       close;

  assign in_ready = !job_r.valid || job_taken;
  assign accept   = in_valid && in_ready;
  assign job      = job_r;

  always_comb begin
    base_crc = open_r ? crc_r : '0;
    base_cnt = open_r ? cnt_r : '0;
    base_seq = open_r ? seq_r : start_seq_r;
    new_crc  = psc_pkg::crc8_step(base_crc, in_data);
    new_cnt  = base_cnt + 1'b1;
    close    = in_last || (new_cnt >= psc_pkg::LEN_FULL);
    next_seq = psc_pkg::seq_inc(base_seq);

    crc_nxt = close ? '0 : new_crc;
    cnt_nxt = close ? '0 : new_cnt;
    seq_nxt = close ? next_seq : base_seq;

    job_nxt         = job_r;
    job_nxt.valid   = accept || (job_r.valid && !job_taken);
    if (accept) begin
      job_nxt.data    = in_data;
      job_nxt.seq     = base_seq;
      job_nxt.end_seq = next_seq;
      job_nxt.len     = new_cnt;
      job_nxt.crc     = psc_pkg::rev8(new_crc);
      job_nxt.ptype   = packet_type_r;
      job_nxt.close   = close;
      job_nxt.last    = in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_type_r <= '0;
      start_seq_r   <= '0;
      crc_r         <= '0;
      cnt_r         <= '0;
      seq_r         <= '0;
      open_r        <= 1'b0;
      job_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          psc_pkg::REG_PACKET_TYPE:    packet_type_r <= cfg_wdata;
          psc_pkg::REG_START_SEQUENCE: start_seq_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        crc_r  <= crc_nxt;
        cnt_r  <= cnt_nxt;
        seq_r  <= seq_nxt;
        open_r <= !in_last;
      end
      job_r <= job_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/psc_emitter.sv
// Expands a job via the output register: echo, trailer on close, end on last.
// Depends on psc_pkg.
`default_nettype none

module psc_emitter (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire psc_pkg::job_t                  job,
  output      logic                           job_taken,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [psc_pkg::KIND_W-1:0]     out_kind,
  output      logic [psc_pkg::OUT_DATA_W-1:0] out_data,
  output      logic                           out_last
);

  logic [psc_pkg::KIND_W-1:0]     idx_r, idx_nxt;
  logic                           valid_r;
  logic [psc_pkg::KIND_W-1:0]     kind_r;
  logic [psc_pkg::OUT_DATA_W-1:0] data_r;
  logic                           last_r;

  logic                           load;
  logic                           final_word;
  logic [psc_pkg::BYTE_W-1:0]     w_byte;
  logic [psc_pkg::SEQ_W-1:0]      w_seq;
  logic [psc_pkg::LEN_W-1:0]      w_len;
  logic [psc_pkg::CRC_W-1:0]      w_crc;
  logic [psc_pkg::TYPE_W-1:0]     w_type;

  assign load      = !valid_r || out_ready;
  assign job_taken = load && job.valid && final_word;

  always_comb begin
    w_byte     = '0;
    w_seq      = job.seq;
    w_len      = '0;
    w_crc      = '0;
    w_type     = job.ptype;
    final_word = 1'b1;
    idx_nxt    = psc_pkg::KIND_ECHO;
    unique case (idx_r)
      psc_pkg::KIND_ECHO: begin
        w_byte = job.data;
        if (job.close) begin
          final_word = 1'b0;
          idx_nxt    = psc_pkg::KIND_TRAILER;
        end
      end
      psc_pkg::KIND_TRAILER: begin
        w_len = job.len;
        w_crc = job.crc;
        if (job.last) begin
          final_word = 1'b0;
          idx_nxt    = psc_pkg::KIND_END;
        end
      end
      psc_pkg::KIND_END: begin
        w_seq  = job.end_seq;
        w_type = psc_pkg::END_TYPE_CODE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= psc_pkg::KIND_ECHO;
    end else if (load) begin
      valid_r <= job.valid;
      if (job.valid) begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && job.valid) begin
      kind_r <= idx_r;
      data_r <= {2'b00, w_type, w_crc, w_len, w_seq, w_byte};
      last_r <= final_word;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_data  = data_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire
